// File: hw/rtl/afi_flip_angle_b1_map_unit_macros.svh
// ----------------------------------------------------------------------------
// afi flip angle b1 map assertion macros
// concurrent check helpers for the rtl file that asserts
// ----------------------------------------------------------------------------
`ifndef AFI_FLIP_ANGLE_B1_MAP_UNIT_MACROS_SVH
`define AFI_FLIP_ANGLE_B1_MAP_UNIT_MACROS_SVH

// same-cycle implication, disabled during reset
`define AFM_CHECK(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("afm check failed");

// next-cycle implication, disabled during reset
`define AFM_CHECK_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("afm next-cycle check failed");

`endif

// File: hw/rtl/afm_pkg.sv
// ----------------------------------------------------------------------------
// afm package
// payload types, status codes, register indexes and fixed-point constants
// ----------------------------------------------------------------------------
package afm_pkg;

    typedef struct packed {
        logic [15:0] signal_first;
        logic [15:0] signal_second;
        logic        in_mask;
    } in_item_t;

    typedef struct packed {
        logic [15:0] flip_angle;
        logic [15:0] b1_ratio;
        logic [1:0]  status;
    } out_item_t;

    typedef enum logic [1:0] {
        STATUS_OK     = 2'd0,
        STATUS_MASKED = 2'd1,
        STATUS_ZERO   = 2'd2
    } status_t;

    localparam logic [1:0] REG_TR_RATIO      = 2'd0;
    localparam logic [1:0] REG_NOMINAL_ANGLE = 2'd1;
    localparam logic [1:0] REG_MASK_ENABLE   = 2'd2;

    // cordic word width and root word width
    localparam int ANG_W = 34;
    localparam int SQ_W  = 62;

    localparam logic signed [ANG_W-1:0] Q30_HALF_PI = 34'sd1686629713;
    localparam logic signed [ANG_W-1:0] Q30_PI      = 34'sd3373259426;
    // 180*256/pi in q16
    localparam logic [29:0] DEG_SCALE = 30'd961263669;
    localparam logic [15:0] FLIP_MAX  = 16'd46080;

    // atan(2^-step) in q30 radians
    function automatic logic signed [ANG_W-1:0] atan_q30(input int step);
        logic signed [ANG_W-1:0] r;
        case (step)
            0: r = 34'sd843314857;
            1: r = 34'sd497837829;
            2: r = 34'sd263043837;
            3: r = 34'sd133525159;
            4: r = 34'sd67021687;
            5: r = 34'sd33543516;
            6: r = 34'sd16775851;
            7: r = 34'sd8388437;
            8: r = 34'sd4194283;
            9: r = 34'sd2097149;
            default: begin
                if (step <= 30) r = ANG_W'(64'd1 << (30 - step));
                else r = '0;
            end
        endcase
        return r;
    endfunction

endpackage

// File: hw/rtl/afm_div_cell.sv
// ----------------------------------------------------------------------------
// afm restoring divider cell
// one quotient bit per cell: shift remainder, trial subtract, pass on
// ----------------------------------------------------------------------------
module afm_div_cell #(
    parameter int RW = 32,
    parameter int QW = 30,
    parameter int SW = 4
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          en,
    input  logic          in_valid,
    input  logic [RW-1:0] in_rem,
    input  logic [RW-1:0] in_div,
    input  logic [QW-1:0] in_q,
    input  logic [SW-1:0] in_side,
    output logic          out_valid,
    output logic [RW-1:0] out_rem,
    output logic [QW-1:0] out_q,
    output logic [SW-1:0] out_side
);

    logic          valid_reg;
    logic [RW-1:0] rem_reg, rem_next;
    logic [QW-1:0] q_reg, q_next;
    logic [SW-1:0] side_reg;
    logic [RW:0]   shifted;
    logic [RW:0]   diff;
    logic          take;

    // trial subtraction
    always_comb begin
        shifted  = {in_rem, 1'b0};
        diff     = shifted - {1'b0, in_div};
        take     = shifted >= {1'b0, in_div};
        rem_next = take ? diff[RW-1:0] : shifted[RW-1:0];
        q_next   = {in_q[QW-2:0], take};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg  <= rem_next;
            q_reg    <= q_next;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_rem   = rem_reg;
    assign out_q     = q_reg;
    assign out_side  = side_reg;

endmodule

// File: hw/rtl/afm_sqrt_cell.sv
// ----------------------------------------------------------------------------
// afm integer square root cell
// one result bit per cell of the digit-by-digit root
// ----------------------------------------------------------------------------
module afm_sqrt_cell #(
    parameter int BIT_POS = 60,
    parameter int SW      = 34
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     en,
    input  logic                     in_valid,
    input  logic [afm_pkg::SQ_W-1:0] in_v,
    input  logic [afm_pkg::SQ_W-1:0] in_res,
    input  logic [SW-1:0]            in_side,
    output logic                     out_valid,
    output logic [afm_pkg::SQ_W-1:0] out_v,
    output logic [afm_pkg::SQ_W-1:0] out_res,
    output logic [SW-1:0]            out_side
);

    localparam logic [afm_pkg::SQ_W-1:0] BIT = afm_pkg::SQ_W'(1) << BIT_POS;

    logic                     valid_reg;
    logic [afm_pkg::SQ_W-1:0] v_reg, v_next;
    logic [afm_pkg::SQ_W-1:0] res_reg, res_next;
    logic [SW-1:0]            side_reg;
    logic [afm_pkg::SQ_W-1:0] trial;

    // compare against res + bit and update
    always_comb begin
        trial = in_res + BIT;
        if (in_v >= trial) begin
            v_next   = in_v - trial;
            res_next = (in_res >> 1) + BIT;
        end else begin
            v_next   = in_v;
            res_next = in_res >> 1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            v_reg    <= v_next;
            res_reg  <= res_next;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_v     = v_reg;
    assign out_res   = res_reg;
    assign out_side  = side_reg;

endmodule

// File: hw/rtl/afm_cordic_cell.sv
// ----------------------------------------------------------------------------
// afm cordic vectoring cell
// one micro-rotation per cell, steering y toward zero
// ----------------------------------------------------------------------------
module afm_cordic_cell #(
    parameter int STEP = 0,
    parameter int SW   = 2
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             en,
    input  logic                             in_valid,
    input  logic signed [afm_pkg::ANG_W-1:0] in_x,
    input  logic signed [afm_pkg::ANG_W-1:0] in_y,
    input  logic signed [afm_pkg::ANG_W-1:0] in_ang,
    input  logic [SW-1:0]                    in_side,
    output logic                             out_valid,
    output logic signed [afm_pkg::ANG_W-1:0] out_x,
    output logic signed [afm_pkg::ANG_W-1:0] out_y,
    output logic signed [afm_pkg::ANG_W-1:0] out_ang,
    output logic [SW-1:0]                    out_side
);

    localparam logic signed [afm_pkg::ANG_W-1:0] ATAN = afm_pkg::atan_q30(STEP);

    logic                             valid_reg;
    logic signed [afm_pkg::ANG_W-1:0] x_reg, x_next;
    logic signed [afm_pkg::ANG_W-1:0] y_reg, y_next;
    logic signed [afm_pkg::ANG_W-1:0] ang_reg, ang_next;
    logic [SW-1:0]                    side_reg;
    logic signed [afm_pkg::ANG_W-1:0] xs;
    logic signed [afm_pkg::ANG_W-1:0] ys;

    // rotate by +-atan(2^-step), floor shifts
    always_comb begin
        xs = in_x >>> STEP;
        ys = in_y >>> STEP;
        if (!in_y[afm_pkg::ANG_W-1]) begin
            x_next   = in_x + ys;
            y_next   = in_y - xs;
            ang_next = in_ang + ATAN;
        end else begin
            x_next   = in_x - ys;
            y_next   = in_y + xs;
            ang_next = in_ang - ATAN;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg    <= x_next;
            y_reg    <= y_next;
            ang_reg  <= ang_next;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_x     = x_reg;
    assign out_y     = y_reg;
    assign out_ang   = ang_reg;
    assign out_side  = side_reg;

endmodule

// File: hw/rtl/afi_flip_angle_b1_map_unit.sv
// ----------------------------------------------------------------------------
// afi flip angle b1 map unit
// per-voxel flip angle and b1 ratio from a dual-tr acquisition
// ----------------------------------------------------------------------------
// One voxel is taken per clock and one result leaves per clock, in order,
// whenever the row advances. The row is made of 30 restoring-division
// cells for the cosine argument, 31 square-root cells, ACOS_ITERATIONS
// cordic cells and 16 division cells for the b1 ratio, plus nine register
// stages around them and the output register. The whole row advances
// together; it holds only when the output register is full and not taken
// and the last cell carries a voxel, so bubbles keep draining and input
// keeps flowing while a result waits.
// Configuration registers are written through a plain write port; the
// user must write them only while no voxel is in flight, as the block
// itself does not enforce it.
`include "afi_flip_angle_b1_map_unit_macros.svh"

module afi_flip_angle_b1_map_unit #(
    parameter int SIGNAL_BITS     = 16,
    parameter int ACOS_ITERATIONS = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  afm_pkg::in_item_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output afm_pkg::out_item_t m_data,
    input  logic               cfg_wr_en,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data
);

    localparam int SIG_EFF = (SIGNAL_BITS < 16) ? SIGNAL_BITS : 16;
    localparam logic [15:0] SIG_MASK = 16'((32'd1 << SIG_EFF) - 32'd1);
    localparam int NA = 30;
    localparam int NB = 31;
    localparam int NC = ACOS_ITERATIONS;
    localparam int ND = 16;
    localparam int AS_W = 36;
    localparam int BS_W = 34;
    localparam int DS_W = 51;
    localparam int AW = afm_pkg::ANG_W;
    localparam int QW = afm_pkg::SQ_W;

    // configuration registers
    logic [15:0] tr_ratio_reg;
    logic [15:0] nominal_angle_reg;
    logic        mask_enable_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tr_ratio_reg      <= 16'd1280;
            nominal_angle_reg <= 16'd15360;
            mask_enable_reg   <= 1'b0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                afm_pkg::REG_TR_RATIO:      tr_ratio_reg      <= cfg_data;
                afm_pkg::REG_NOMINAL_ANGLE: nominal_angle_reg <= cfg_data;
                afm_pkg::REG_MASK_ENABLE:   mask_enable_reg   <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // row advance control
    logic en;
    logic out_free;
    logic last_valid;
    logic m_valid_reg;
    afm_pkg::out_item_t m_data_reg, m_data_next;

    assign out_free = !m_valid_reg || m_ready;
    assign en       = out_free || !last_valid;
    assign s_ready  = en;

    // stage 0: input capture and special-case status
    logic             st0_valid_reg;
    logic [15:0]      st0_s1_reg, st0_s2_reg, s1_in, s2_in;
    afm_pkg::status_t st0_status_reg, st0_status_next;

    always_comb begin
        s1_in = s_data.signal_first & SIG_MASK;
        s2_in = s_data.signal_second & SIG_MASK;
        if (mask_enable_reg && !s_data.in_mask) begin
            st0_status_next = afm_pkg::STATUS_MASKED;
        end else if (s1_in == 16'd0) begin
            st0_status_next = afm_pkg::STATUS_ZERO;
        end else begin
            st0_status_next = afm_pkg::STATUS_OK;
        end
    end

    // stage 1: numerator and denominator
    logic                 st1_valid_reg;
    afm_pkg::status_t     st1_status_reg;
    logic signed [33:0]   st1_num_reg, st1_den_reg;
    logic [33:0]          num_next, den_next;

    always_comb begin
        num_next = 34'(st0_s2_reg) * 34'(tr_ratio_reg) - (34'(st0_s1_reg) << 8);
        den_next = 34'(st0_s1_reg) * 34'(tr_ratio_reg) - (34'(st0_s2_reg) << 8);
    end

    // stage 2: magnitudes, sign and saturation of the cosine argument
    logic             st2_valid_reg;
    afm_pkg::status_t st2_status_reg;
    logic [31:0]      st2_an_reg, st2_ad_reg;
    logic             st2_neg_reg, st2_tsat_reg;
    logic [33:0]      an_full, ad_full;
    logic             neg_next;

    always_comb begin
        an_full  = st1_num_reg[33] ? 34'(-st1_num_reg) : 34'(st1_num_reg);
        ad_full  = st1_den_reg[33] ? 34'(-st1_den_reg) : 34'(st1_den_reg);
        neg_next = (st1_den_reg == 34'sd0) ? st1_num_reg[33]
                                           : (st1_num_reg[33] ^ st1_den_reg[33]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st0_valid_reg <= 1'b0;
            st1_valid_reg <= 1'b0;
            st2_valid_reg <= 1'b0;
        end else if (en) begin
            st0_valid_reg <= s_valid;
            st1_valid_reg <= st0_valid_reg;
            st2_valid_reg <= st1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            st0_s1_reg     <= s1_in;
            st0_s2_reg     <= s2_in;
            st0_status_reg <= st0_status_next;
            st1_status_reg <= st0_status_reg;
            st1_num_reg    <= $signed(num_next);
            st1_den_reg    <= $signed(den_next);
            st2_status_reg <= st1_status_reg;
            st2_an_reg     <= an_full[31:0];
            st2_ad_reg     <= ad_full[31:0];
            st2_neg_reg    <= neg_next;
            st2_tsat_reg   <= (st1_den_reg == 34'sd0) || (an_full[31:0] >= ad_full[31:0]);
        end
    end

    // cosine argument division row, side {status, neg, tsat, divisor}
    logic            a_valid [0:NA];
    logic [31:0]     a_rem   [0:NA];
    logic [NA-1:0]   a_q     [0:NA];
    logic [AS_W-1:0] a_side  [0:NA];

    assign a_valid[0] = st2_valid_reg;
    assign a_rem[0]   = st2_an_reg;
    assign a_q[0]     = '0;
    assign a_side[0]  = {st2_status_reg, st2_neg_reg, st2_tsat_reg, st2_ad_reg};

    for (genvar k = 0; k < NA; k++) begin : g_tdiv
        afm_div_cell #(.RW(32), .QW(NA), .SW(AS_W)) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (en),
            .in_valid (a_valid[k]),
            .in_rem   (a_rem[k]),
            .in_div   (a_side[k][31:0]),
            .in_q     (a_q[k]),
            .in_side  (a_side[k]),
            .out_valid(a_valid[k+1]),
            .out_rem  (a_rem[k+1]),
            .out_q    (a_q[k+1]),
            .out_side (a_side[k+1])
        );
    end

    // stage 3: |t| ; stage 4: radicand 1 - t^2
    logic             st3_valid_reg, st4_valid_reg;
    afm_pkg::status_t st3_status_reg, st4_status_reg;
    logic             st3_neg_reg, st4_neg_reg;
    logic [30:0]      st3_mag_reg, st4_mag_reg;
    logic [QW-1:0]    st4_v_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st3_valid_reg <= 1'b0;
            st4_valid_reg <= 1'b0;
        end else if (en) begin
            st3_valid_reg <= a_valid[NA];
            st4_valid_reg <= st3_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            st3_status_reg <= afm_pkg::status_t'(a_side[NA][35:34]);
            st3_neg_reg    <= a_side[NA][33];
            st3_mag_reg    <= a_side[NA][32] ? 31'h4000_0000 : {1'b0, a_q[NA]};
            st4_status_reg <= st3_status_reg;
            st4_neg_reg    <= st3_neg_reg;
            st4_mag_reg    <= st3_mag_reg;
            st4_v_reg      <= (QW'(1) << 60) - QW'(st3_mag_reg) * QW'(st3_mag_reg);
        end
    end

    // square root row, side {status, neg, mag}
    logic            b_valid [0:NB];
    logic [QW-1:0]   b_v     [0:NB];
    logic [QW-1:0]   b_res   [0:NB];
    logic [BS_W-1:0] b_side  [0:NB];

    assign b_valid[0] = st4_valid_reg;
    assign b_v[0]     = st4_v_reg;
    assign b_res[0]   = '0;
    assign b_side[0]  = {st4_status_reg, st4_neg_reg, st4_mag_reg};

    for (genvar k = 0; k < NB; k++) begin : g_sqrt
        afm_sqrt_cell #(.BIT_POS(60 - 2 * k), .SW(BS_W)) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (en),
            .in_valid (b_valid[k]),
            .in_v     (b_v[k]),
            .in_res   (b_res[k]),
            .in_side  (b_side[k]),
            .out_valid(b_valid[k+1]),
            .out_v    (b_v[k+1]),
            .out_res  (b_res[k+1]),
            .out_side (b_side[k+1])
        );
    end

    // stage 5: cordic start vector, rotated by -90 degrees for negative t
    logic                 st5_valid_reg;
    afm_pkg::status_t     st5_status_reg;
    logic signed [AW-1:0] st5_x_reg, st5_y_reg, st5_ang_reg;
    logic signed [AW-1:0] root_s, mag_s;

    assign root_s = $signed(AW'(b_res[NB][30:0]));
    assign mag_s  = $signed(AW'(b_side[NB][30:0]));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st5_valid_reg <= 1'b0;
        end else if (en) begin
            st5_valid_reg <= b_valid[NB];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            st5_status_reg <= afm_pkg::status_t'(b_side[NB][33:32]);
            if (b_side[NB][31]) begin
                st5_x_reg   <= root_s;
                st5_y_reg   <= mag_s;
                st5_ang_reg <= afm_pkg::Q30_HALF_PI;
            end else begin
                st5_x_reg   <= mag_s;
                st5_y_reg   <= root_s;
                st5_ang_reg <= '0;
            end
        end
    end

    // cordic row, side {status}
    logic                 c_valid [0:NC];
    logic signed [AW-1:0] c_x     [0:NC];
    logic signed [AW-1:0] c_y     [0:NC];
    logic signed [AW-1:0] c_ang   [0:NC];
    logic [1:0]           c_side  [0:NC];

    assign c_valid[0] = st5_valid_reg;
    assign c_x[0]     = st5_x_reg;
    assign c_y[0]     = st5_y_reg;
    assign c_ang[0]   = st5_ang_reg;
    assign c_side[0]  = st5_status_reg;

    for (genvar k = 0; k < NC; k++) begin : g_cordic
        afm_cordic_cell #(.STEP(k), .SW(2)) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (en),
            .in_valid (c_valid[k]),
            .in_x     (c_x[k]),
            .in_y     (c_y[k]),
            .in_ang   (c_ang[k]),
            .in_side  (c_side[k]),
            .out_valid(c_valid[k+1]),
            .out_x    (c_x[k+1]),
            .out_y    (c_y[k+1]),
            .out_ang  (c_ang[k+1]),
            .out_side (c_side[k+1])
        );
    end

    // stage 6: clamp angle to [0, pi] and scale to degrees
    // stage 7: round and clamp flip angle
    // stage 8: b1 dividend and saturation test
    logic             st6_valid_reg, st7_valid_reg, st8_valid_reg;
    afm_pkg::status_t st6_status_reg, st7_status_reg, st8_status_reg;
    logic [QW-1:0]    st6_prod_reg;
    logic [15:0]      st7_flip_reg, st8_flip_reg;
    logic [31:0]      st8_dvd_reg, st8_div_reg;
    logic             st8_sat_reg;
    logic [31:0]      ang_clamped;
    logic [QW:0]      rounded;
    logic [16:0]      flip_raw;
    logic [31:0]      dvd_next, div_next;

    always_comb begin
        if (c_ang[NC] < 0) begin
            ang_clamped = '0;
        end else if (c_ang[NC] > afm_pkg::Q30_PI) begin
            ang_clamped = afm_pkg::Q30_PI[31:0];
        end else begin
            ang_clamped = c_ang[NC][31:0];
        end
        rounded  = {1'b0, st6_prod_reg} + ((QW + 1)'(1) << 45);
        flip_raw = rounded[62:46];
        dvd_next = 32'({st7_flip_reg, 12'b0}) + 32'(nominal_angle_reg[15:1]);
        div_next = {nominal_angle_reg, 16'b0};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st6_valid_reg <= 1'b0;
            st7_valid_reg <= 1'b0;
            st8_valid_reg <= 1'b0;
        end else if (en) begin
            st6_valid_reg <= c_valid[NC];
            st7_valid_reg <= st6_valid_reg;
            st8_valid_reg <= st7_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            st6_status_reg <= afm_pkg::status_t'(c_side[NC]);
            st6_prod_reg   <= QW'(ang_clamped) * QW'(afm_pkg::DEG_SCALE);
            st7_status_reg <= st6_status_reg;
            st7_flip_reg   <= (flip_raw > 17'(afm_pkg::FLIP_MAX)) ? afm_pkg::FLIP_MAX
                                                                 : flip_raw[15:0];
            st8_status_reg <= st7_status_reg;
            st8_flip_reg   <= st7_flip_reg;
            st8_dvd_reg    <= dvd_next;
            st8_div_reg    <= div_next;
            st8_sat_reg    <= dvd_next >= div_next;
        end
    end

    // b1 division row, side {status, sat, flip, divisor}
    logic            d_valid [0:ND];
    logic [31:0]     d_rem   [0:ND];
    logic [ND-1:0]   d_q     [0:ND];
    logic [DS_W-1:0] d_side  [0:ND];

    assign d_valid[0] = st8_valid_reg;
    assign d_rem[0]   = st8_dvd_reg;
    assign d_q[0]     = '0;
    assign d_side[0]  = {st8_status_reg, st8_sat_reg, st8_flip_reg, st8_div_reg};

    for (genvar k = 0; k < ND; k++) begin : g_bdiv
        afm_div_cell #(.RW(32), .QW(ND), .SW(DS_W)) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (en),
            .in_valid (d_valid[k]),
            .in_rem   (d_rem[k]),
            .in_div   (d_side[k][31:0]),
            .in_q     (d_q[k]),
            .in_side  (d_side[k]),
            .out_valid(d_valid[k+1]),
            .out_rem  (d_rem[k+1]),
            .out_q    (d_q[k+1]),
            .out_side (d_side[k+1])
        );
    end

    assign last_valid = d_valid[ND];

    // result selection by status
    always_comb begin
        m_data_next.status = d_side[ND][50:49];
        case (afm_pkg::status_t'(d_side[ND][50:49]))
            afm_pkg::STATUS_MASKED: begin
                m_data_next.flip_angle = 16'd0;
                m_data_next.b1_ratio   = 16'd4096;
            end
            afm_pkg::STATUS_ZERO: begin
                m_data_next.flip_angle = 16'd0;
                m_data_next.b1_ratio   = 16'd0;
            end
            default: begin
                m_data_next.flip_angle = d_side[ND][47:32];
                m_data_next.b1_ratio   = d_side[ND][48] ? 16'hFFFF : d_q[ND];
            end
        endcase
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_free) begin
            m_valid_reg <= last_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free && last_valid) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // checks
    `AFM_CHECK(a_tdiv_rem, aclk, aresetn, a_valid[NA] && !a_side[NA][32], a_rem[NA] < a_side[NA][31:0])
    `AFM_CHECK(a_root_rem, aclk, aresetn, b_valid[NB], b_v[NB] <= (b_res[NB] << 1))
    `AFM_CHECK(a_bdiv_rem, aclk, aresetn, d_valid[ND] && !d_side[ND][48], d_rem[ND] < d_side[ND][31:0])
    `AFM_CHECK_NEXT(a_out_load, aclk, aresetn, out_free && last_valid, m_valid_reg)

endmodule
